/* src/itoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII package
// Shared types, constants and the digit encoding used by the converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Width of the integer being converted.
  localparam int WORD_BITS = 16;
  // Width of the radix field.
  localparam int RADIX_W = 6;
  // Width of one ASCII character.
  localparam int CHAR_W = 8;
  // Width of the divider's step counter.
  localparam int STEP_W = $clog2(WORD_BITS);
  // Depth of the queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_TEN  = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] DIGIT_NINE = RADIX_W'(9);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'

  // One input transaction.
  typedef struct packed {
    logic signed [WORD_BITS-1:0] value;
    logic [RADIX_W-1:0]          radix;
  } in_t;

  // One output transaction.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  // A classified item as it waits in the queue.
  typedef struct packed {
    logic                 minus;
    logic [RADIX_W-1:0]   base;
    logic [WORD_BITS-1:0] magnitude;
  } cls_t;

  // Request to the divider.
  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [RADIX_W-1:0]   divisor;
  } div_req_t;

  // Answer from the divider.
  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quotient;
    logic [RADIX_W-1:0]   remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_SIGN,
    BK_EMIT,
    BK_OUT
  } back_state_e;

  // Maps a digit value to its ASCII character, lower-case above nine.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d > DIGIT_NINE) begin
      return dw - CHAR_W'(RADIX_TEN) + CHAR_A;
    end
    return dw + CHAR_ZERO;
  endfunction

endpackage

/* src/itoa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII front end
// Accepts input transactions, clamps the base and forms the magnitude.
// ----------------------------------------------------------------------------
module itoa_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  itoa_pkg::in_t        in_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output itoa_pkg::cls_t       push_data_o
);

  logic [itoa_pkg::RADIX_W-1:0]   base;
  logic [itoa_pkg::WORD_BITS-1:0] pattern;
  logic                           minus;

  always_comb begin
    if (in_data_i.radix < itoa_pkg::RADIX_MIN) begin
      base = itoa_pkg::RADIX_MIN;
    end else if (in_data_i.radix > itoa_pkg::RADIX_MAX) begin
      base = itoa_pkg::RADIX_MAX;
    end else begin
      base = in_data_i.radix;
    end
    pattern = in_data_i.value;
    // Only base ten shows a sign; other bases print the raw bit pattern.
    minus = pattern[itoa_pkg::WORD_BITS-1] && (base == itoa_pkg::RADIX_TEN);
  end

  assign push_data_o.minus     = minus;
  assign push_data_o.base      = base;
  assign push_data_o.magnitude = minus ? ((~pattern) + itoa_pkg::WORD_BITS'(1)) : pattern;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

/* src/itoa_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module itoa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itoa_pkg::cls_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output itoa_pkg::cls_t pop_data_o
);

  localparam int PW = (itoa_pkg::QUEUE_DEPTH > 1) ? $clog2(itoa_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(itoa_pkg::QUEUE_DEPTH + 1);

  itoa_pkg::cls_t entry_q [itoa_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    if (p == PW'(itoa_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full_o     = (count_q == CW'(itoa_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/itoa_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itoa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itoa_pkg::div_req_t req_i,
  output itoa_pkg::div_rsp_t rsp_o
);

  localparam int W  = itoa_pkg::WORD_BITS;
  localparam int RW = itoa_pkg::RADIX_W;

  logic                      busy_q;
  logic                      done_q;
  logic [itoa_pkg::STEP_W-1:0] step_q;
  logic [W-1:0]              quo_q, quo_d;
  logic [RW-1:0]             rem_q, rem_d;
  logic [RW-1:0]             div_q;
  logic [RW:0]               trial;
  logic                      ge;

  // The partial remainder always stays below the divisor, so the shifted
  // trial value fits in one extra bit.
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? RW'(trial - {1'b0, div_q}) : trial[RW-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + itoa_pkg::STEP_W'(1);
        if (step_q == itoa_pkg::STEP_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && step_q == itoa_pkg::STEP_W'(W - 1) |=> done_q && !busy_q)
    else $error("divider missed its done pulse");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reports done while still busy");

endmodule

/* src/itoa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII back end
// Divides out the digits, stores them and plays them out most significant first.
// ----------------------------------------------------------------------------
module itoa_back #(
  parameter int MAX_CHARS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  itoa_pkg::cls_t     q_data_i,
  output logic               pop_o,
  output itoa_pkg::div_req_t div_req_o,
  input  itoa_pkg::div_rsp_t div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output itoa_pkg::out_t     out_data_o
);

  localparam int W  = itoa_pkg::WORD_BITS;
  localparam int AW = $clog2(MAX_CHARS);
  localparam int CW = $clog2(MAX_CHARS + 1);

  itoa_pkg::back_state_e state_q, state_d;

  logic [W-1:0]                  quot_q;
  logic [itoa_pkg::RADIX_W-1:0]  base_q;
  logic                          minus_q;
  logic [CW-1:0]                 count_q;
  logic [AW-1:0]                 idx_q;
  logic [itoa_pkg::CHAR_W-1:0]   char_q;
  logic                          last_q;
  logic                          out_valid_q;

  logic [itoa_pkg::CHAR_W-1:0]   store_q [MAX_CHARS];

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [itoa_pkg::CHAR_W-1:0]   wr_data;
  logic                          rd_en;
  logic                          out_take;
  logic                          q_zero;
  logic                          sign_fits;
  logic                          div_finish;
  logic [CW-1:0]                 count_m1;

  assign out_take   = out_valid_q && !out_stall_i;
  assign q_zero     = (q_data_i.magnitude == '0);
  assign sign_fits  = minus_q && (count_q < CW'(MAX_CHARS));
  assign div_finish = (div_rsp_i.quotient == '0) || (count_q + CW'(1) == CW'(MAX_CHARS));
  assign count_m1   = count_q - CW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = q_zero ? itoa_pkg::BK_SIGN : itoa_pkg::BK_START;
        end
      end
      itoa_pkg::BK_START: state_d = itoa_pkg::BK_WAIT;
      itoa_pkg::BK_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = div_finish ? itoa_pkg::BK_SIGN : itoa_pkg::BK_START;
        end
      end
      itoa_pkg::BK_SIGN: state_d = itoa_pkg::BK_EMIT;
      itoa_pkg::BK_EMIT: state_d = itoa_pkg::BK_OUT;
      itoa_pkg::BK_OUT: begin
        if (out_take) begin
          state_d = last_q ? itoa_pkg::BK_IDLE : itoa_pkg::BK_EMIT;
        end
      end
      default: state_d = itoa_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o              = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = quot_q;
    div_req_o.divisor  = base_q;
    wr_en              = 1'b0;
    wr_addr            = count_q[AW-1:0];
    wr_data            = itoa_pkg::CHAR_ZERO;
    rd_en              = 1'b0;
    unique case (state_q)
      itoa_pkg::BK_IDLE: begin
        pop_o = q_valid_i;
        if (q_valid_i && q_zero) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = itoa_pkg::CHAR_ZERO;
        end
      end
      itoa_pkg::BK_START: div_req_o.start = 1'b1;
      itoa_pkg::BK_WAIT: begin
        wr_en   = div_rsp_i.done;
        wr_data = itoa_pkg::digit_char(div_rsp_i.remainder);
      end
      itoa_pkg::BK_SIGN: begin
        wr_en   = sign_fits;
        wr_data = itoa_pkg::CHAR_MINUS;
      end
      itoa_pkg::BK_EMIT: rd_en = 1'b1;
      itoa_pkg::BK_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::BK_IDLE;
      count_q     <= '0;
      quot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == itoa_pkg::BK_IDLE && q_valid_i) begin
        quot_q  <= q_data_i.magnitude;
        count_q <= q_zero ? CW'(1) : '0;
      end else if (state_q == itoa_pkg::BK_WAIT && div_rsp_i.done) begin
        quot_q  <= div_rsp_i.quotient;
        count_q <= count_q + CW'(1);
      end else if (state_q == itoa_pkg::BK_SIGN && sign_fits) begin
        count_q <= count_q + CW'(1);
      end
      if (state_q == itoa_pkg::BK_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == itoa_pkg::BK_IDLE && q_valid_i) begin
      base_q  <= q_data_i.base;
      minus_q <= q_data_i.minus;
    end
    if (state_q == itoa_pkg::BK_SIGN) begin
      // Playback starts at the top entry; the sign, when written, is it.
      idx_q <= sign_fits ? count_q[AW-1:0] : count_m1[AW-1:0];
    end else if (state_q == itoa_pkg::BK_OUT && out_take && !last_q) begin
      idx_q <= idx_q - AW'(1);
    end
    if (state_q == itoa_pkg::BK_EMIT) begin
      last_q <= (idx_q == '0);
    end
  end

  // Digit store, least significant character at entry zero.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      char_q <= store_q[idx_q];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.character = char_q;
  assign out_data_o.last      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_CHARS))
    else $error("digit count exceeds the store depth");

  a_out_only_when_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == itoa_pkg::BK_OUT)
    else $error("output valid outside playback");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && last_q |=> state_q == itoa_pkg::BK_IDLE)
    else $error("back end did not finish after the last character");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == itoa_pkg::BK_START || state_q == itoa_pkg::BK_SIGN)
    else $error("popped item not taken into work");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itoa_pkg::BK_EMIT |-> count_q != '0)
    else $error("playback with an empty digit store");

endmodule

/* src/integer_to_ascii_radix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII in any radix
// Converts a signed 16-bit integer into its text in base 2 to 36.
// ----------------------------------------------------------------------------
// Each input transaction carries a signed 16-bit value and a radix; the block
// answers with one output transaction per character, most significant first,
// and flags the final character with last. Digits above nine are lower-case
// letters, zero prints as "0", and a minus sign appears only for negative
// values in base ten (other bases print the raw 16-bit pattern). A radix
// below 2 is treated as 2 and one above 36 as 36. Work is done one item at a
// time: for each digit the back end launches the bit-serial divider, which
// forms sixteen quotient bits, and takes the remainder as the digit; once
// the digits and any sign are stored, each character is read out of the
// digit store and offered on the output, where it is held while the output
// side stalls. A two-entry queue sits between the input side and the
// converter, so new items are taken while earlier ones are still being
// converted or are waiting to be delivered. MAX_CHARS sets the depth of the
// digit store; when it is smaller than the text, only the low MAX_CHARS
// characters come out.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
  parameter int MAX_CHARS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  itoa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output itoa_pkg::out_t out_data_o
);

  logic               push;
  logic               full;
  itoa_pkg::cls_t     push_data;
  logic               pop;
  logic               q_valid;
  itoa_pkg::cls_t     q_data;
  itoa_pkg::div_req_t div_req;
  itoa_pkg::div_rsp_t div_rsp;

  // Front end: clamps the radix and forms the magnitude to divide.
  itoa_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue of classified items awaiting conversion.
  itoa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // Divider producing one digit per run.
  itoa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Back end: digit loop, digit store and character playback.
  itoa_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII converter testbench
// Sends signed integers with a radix, predicts the text of each one and
// checks every output character and its last flag in order, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;

  // Cycles without any accepted transaction before the run is declared hung.
  // It has to cover a worst-case item (base two) plus the input gaps
  // and output stalls.
  localparam int HANG_LIMIT = 4000;
  // Cycles to wait once all characters have arrived, to catch stray output.
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int TEXT_DEPTH = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  itoa_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  itoa_pkg::out_t out_data;

  // Characters still to come, oldest first.
  itoa_pkg::out_t pending_chars[$];
  int mismatches = 0;
  // Upper bounds of the random idle cycles drawn per transaction.
  int in_gap_max = 12;
  int out_wait_max = 12;

  integer_to_ascii_radix u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Works out the text of one number and queues its characters, most
  // significant first, with last set on the final one.
  function automatic void render_number(input itoa_pkg::in_t item);
    logic [itoa_pkg::WORD_BITS-1:0] pattern;
    logic [itoa_pkg::WORD_BITS-1:0] magnitude;
    logic [itoa_pkg::RADIX_W-1:0] base;
    logic [itoa_pkg::RADIX_W-1:0] digit;
    logic [itoa_pkg::CHAR_W-1:0] text[TEXT_DEPTH];
    logic minus;
    int count;
    itoa_pkg::out_t entry;
    pattern = item.value;
    base = item.radix;
    if (base < itoa_pkg::RADIX_MIN) begin
      base = itoa_pkg::RADIX_MIN;
    end
    if (base > itoa_pkg::RADIX_MAX) begin
      base = itoa_pkg::RADIX_MAX;
    end
    // Only base ten prints a sign; elsewhere the raw bit pattern is used.
    minus = pattern[itoa_pkg::WORD_BITS-1] && (base == itoa_pkg::RADIX_TEN);
    magnitude = minus ? itoa_pkg::WORD_BITS'(~pattern + 1'b1) : pattern;
    count = 0;
    if (magnitude == '0) begin
      text[0] = itoa_pkg::CHAR_ZERO;
      count = 1;
    end else begin
      while (magnitude != '0 && count < TEXT_DEPTH) begin
        digit = itoa_pkg::RADIX_W'(magnitude % itoa_pkg::WORD_BITS'(base));
        if (digit > itoa_pkg::DIGIT_NINE) begin
          text[count] = itoa_pkg::CHAR_W'(digit) - itoa_pkg::CHAR_W'(itoa_pkg::RADIX_TEN)
                        + itoa_pkg::CHAR_A;
        end else begin
          text[count] = itoa_pkg::CHAR_W'(digit) + itoa_pkg::CHAR_ZERO;
        end
        count++;
        magnitude = magnitude / itoa_pkg::WORD_BITS'(base);
      end
    end
    if (minus && count < TEXT_DEPTH) begin
      text[count] = itoa_pkg::CHAR_MINUS;
      count++;
    end
    for (int k = 0; k < count; k++) begin
      entry.character = text[count - 1 - k];
      entry.last = (k == count - 1);
      pending_chars.push_back(entry);
    end
  endfunction

  // Offers one number after a random gap and returns at the edge where the
  // transaction is taken. Valid stays high on return, so a following call
  // with no gap keeps the input busy without a bubble.
  task automatic send_number(input logic signed [itoa_pkg::WORD_BITS-1:0] value,
                             input logic [itoa_pkg::RADIX_W-1:0] radix);
    int gap;
    itoa_pkg::in_t item;
    gap = $urandom_range(0, in_gap_max);
    item.value = value;
    item.radix = radix;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    render_number(item);
  endtask

  // Small magnitudes in half of the draws, which give short texts, mixed with full-width
  // patterns and values close to both ends of the range.
  function automatic logic signed [itoa_pkg::WORD_BITS-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return itoa_pkg::WORD_BITS'($urandom);
      1: return itoa_pkg::WORD_BITS'($urandom_range(0, 40));
      2: return -itoa_pkg::WORD_BITS'($urandom_range(1, 40));
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          return 16'sh7fff - itoa_pkg::WORD_BITS'($urandom_range(0, 15));
        end
        return 16'sh8000 + itoa_pkg::WORD_BITS'($urandom_range(0, 15));
      end
    endcase
  endfunction

  // Extremes of both fields, both radix saturations, zero, the sign in base
  // ten, the most negative value and letter digits.
  task automatic test_corner_values();
    send_number(16'sd0, 6'd10);
    send_number(16'sd0, 6'd2);
    send_number(16'sd0, 6'd36);
    send_number(16'sd1, 6'd2);
    send_number(-16'sd1, 6'd10);
    send_number(-16'sd1, 6'd2);
    send_number(-16'sd1, 6'd16);
    send_number(16'sd32767, 6'd10);
    send_number(-16'sd32768, 6'd10);
    send_number(-16'sd32768, 6'd2);
    send_number(16'sd32767, 6'd36);
    send_number(-16'sd32768, 6'd36);
    send_number(16'sd35, 6'd36);
    send_number(16'sd10, 6'd11);
    send_number(16'sd9, 6'd10);
    send_number(16'sd12345, 6'd0);
    send_number(16'sd12345, 6'd1);
    send_number(16'sd12345, 6'd37);
    send_number(16'sd12345, 6'd63);
    send_number(-16'sd12345, 6'd10);
    send_number(-16'sd5, 6'd16);
    send_number(16'sd255, 6'd16);
  endtask

  // Any value with any radix code, including the saturated ones.
  task automatic test_any_radix(input int count);
    for (int n = 0; n < count; n++) begin
      send_number(random_value(), itoa_pkg::RADIX_W'($urandom_range(0, 63)));
    end
  endtask

  // Legal bases only, with base ten favored so the sign path is busy.
  task automatic test_legal_radix(input int count);
    logic [itoa_pkg::RADIX_W-1:0] radix;
    for (int n = 0; n < count; n++) begin
      radix = ($urandom_range(0, 2) == 0) ? itoa_pkg::RADIX_TEN
                                          : itoa_pkg::RADIX_W'($urandom_range(2, 36));
      send_number(random_value(), radix);
    end
  endtask

  // No idling on either side, so the input queue fills and the converter
  // never waits on the output.
  task automatic test_full_throughput(input int count);
    in_gap_max = 0;
    out_wait_max = 0;
    test_any_radix(count);
    in_gap_max = 12;
    out_wait_max = 12;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_any_radix(28);
    test_full_throughput(30);
    test_legal_radix(40);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output side: draws a stall length for every character, then accepts it
  // and compares it with the oldest expected character.
  initial begin
    int stall_len;
    itoa_pkg::out_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall_len = $urandom_range(0, out_wait_max);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(posedge clk);
      end while (out_valid !== 1'b1);
      if (pending_chars.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected character %h last %b", out_data.character, out_data.last);
        end
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data.character !== want.character || out_data.last !== want.last) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.character, want.last, out_data.character, out_data.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

/* integer_to_ascii_radix.f */
src/itoa_pkg.sv
src/itoa_front.sv
src/itoa_queue.sv
src/itoa_divider.sv
src/itoa_back.sv
src/integer_to_ascii_radix.sv
verif/testbench.sv
